// File: design/mfr_pkg.sv
`default_nettype none

package mfr_pkg;

   // framing bytes and sizes
   localparam logic [7:0] START_BYTE     = 8'h68;
   localparam logic [7:0] END_BYTE       = 8'h16;
   localparam logic [7:0] ADDR_BYTES     = 8'd4;
   localparam logic [8:0] FRAME_OVERHEAD = 9'd9;

   // register reset values
   localparam logic [15:0] HUNT_TIMEOUT_RESET = 16'd200;
   localparam logic [15:0] BYTE_TIMEOUT_RESET = 16'd100;
   localparam logic [7:0]  MAX_DATA_LEN_RESET = 8'd128;
   localparam logic [7:0]  HUNT_LIMIT_RESET   = 8'd30;

   // register indexes
   localparam logic [1:0] CFG_HUNT_TIMEOUT = 2'd0;
   localparam logic [1:0] CFG_BYTE_TIMEOUT = 2'd1;
   localparam logic [1:0] CFG_MAX_DATA_LEN = 2'd2;
   localparam logic [1:0] CFG_HUNT_LIMIT   = 2'd3;

   // status codes
   localparam logic [3:0] ST_OK             = 4'd0;
   localparam logic [3:0] ST_HUNT_TIMEOUT   = 4'd1;
   localparam logic [3:0] ST_NO_START       = 4'd2;
   localparam logic [3:0] ST_ADDR_TIMEOUT   = 4'd3;
   localparam logic [3:0] ST_CTRL_TIMEOUT   = 4'd4;
   localparam logic [3:0] ST_LEN_TIMEOUT    = 4'd5;
   localparam logic [3:0] ST_LEN_TOO_BIG    = 4'd6;
   localparam logic [3:0] ST_DATA_TIMEOUT   = 4'd7;
   localparam logic [3:0] ST_CSUM_TIMEOUT   = 4'd8;
   localparam logic [3:0] ST_CSUM_MISMATCH  = 4'd9;
   localparam logic [3:0] ST_END_TIMEOUT    = 4'd10;
   localparam logic [3:0] ST_BAD_END        = 4'd11;

   // input item kinds
   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_ABORT = 2'd2
   } op_type;

   // frame phases, one-hot
   typedef enum logic [6:0] {
      PH_HUNT = 7'b0000001,
      PH_ADDR = 7'b0000010,
      PH_CTRL = 7'b0000100,
      PH_LEN  = 7'b0001000,
      PH_DATA = 7'b0010000,
      PH_CSUM = 7'b0100000,
      PH_END  = 7'b1000000
   } phase_type;

   // one result item
   typedef struct packed {
      logic       has_byte;
      logic [7:0] frame_byte;
      logic [8:0] byte_index;
      logic       done_res;
      logic [3:0] status;
      logic [8:0] frame_length;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: design/mfr_deframer.sv
`default_nettype none

module mfr_deframer
   import mfr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   input  wire logic         in_valid,
   input  wire logic [1:0]   in_op,
   input  wire logic [7:0]   in_byte,
   input  wire logic         out_free,
   output logic              step_ready,
   output logic              push,
   output rsp_item_type      push_item
);

   // configuration registers
   logic [15:0] hunt_to_ff;
   logic [15:0] byte_to_ff;
   logic [7:0]  max_len_ff;
   logic [7:0]  hunt_lim_ff;

   // frame state
   phase_type   phase_ff, phase_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  dlen_ff, dlen_in;
   logic [15:0] idle_ff, idle_in;
   logic [8:0]  index_ff, index_in;

   logic        has_res;
   logic        restart;
   logic        fire;
   logic [7:0]  count_inc;
   logic [7:0]  sum_add;
   logic [15:0] idle_inc;
   logic [15:0] tick_limit;
   logic [3:0]  timeout_status;
   rsp_item_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_to_ff  <= HUNT_TIMEOUT_RESET;
         byte_to_ff  <= BYTE_TIMEOUT_RESET;
         max_len_ff  <= MAX_DATA_LEN_RESET;
         hunt_lim_ff <= HUNT_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CFG_HUNT_TIMEOUT: hunt_to_ff  <= csr_wdata;
            CFG_BYTE_TIMEOUT: byte_to_ff  <= csr_wdata;
            CFG_MAX_DATA_LEN: max_len_ff  <= csr_wdata[7:0];
            CFG_HUNT_LIMIT:   hunt_lim_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // timeout status of the current phase
   always_comb begin
      case (phase_ff)
         PH_HUNT: timeout_status = ST_HUNT_TIMEOUT;
         PH_ADDR: timeout_status = ST_ADDR_TIMEOUT;
         PH_CTRL: timeout_status = ST_CTRL_TIMEOUT;
         PH_LEN:  timeout_status = ST_LEN_TIMEOUT;
         PH_DATA: timeout_status = ST_DATA_TIMEOUT;
         PH_CSUM: timeout_status = ST_CSUM_TIMEOUT;
         default: timeout_status = ST_END_TIMEOUT;
      endcase
   end

   assign count_inc = count_ff + 8'd1;
   assign sum_add   = sum_ff + in_byte;
   assign idle_inc  = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;

   // a zero timeout acts like one
   always_comb begin
      tick_limit = (phase_ff == PH_HUNT) ? hunt_to_ff : byte_to_ff;
      if (tick_limit == 16'd0) begin
         tick_limit = 16'd1;
      end
   end

   // one step of the deframer
   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      dlen_in  = dlen_ff;
      idle_in  = idle_ff;
      index_in = index_ff;
      res      = '0;
      has_res  = 1'b0;
      restart  = 1'b0;

      case (op_type'(in_op))
         OP_BYTE: begin
            idle_in = '0;
            case (phase_ff)
               PH_HUNT: begin
                  if (in_byte == START_BYTE) begin
                     sum_in   = in_byte;
                     phase_in = PH_ADDR;
                     count_in = '0;
                     has_res  = 1'b1;
                  end else begin
                     count_in = count_inc;
                     if (count_inc >= hunt_lim_ff || hunt_lim_ff == 8'd0) begin
                        has_res      = 1'b1;
                        res.done_res = 1'b1;
                        res.status   = ST_NO_START;
                        restart      = 1'b1;
                     end
                  end
               end
               PH_ADDR: begin
                  sum_in   = sum_add;
                  count_in = count_inc;
                  if (count_inc >= ADDR_BYTES) begin
                     phase_in = PH_CTRL;
                  end
                  has_res = 1'b1;
               end
               PH_CTRL: begin
                  sum_in   = sum_add;
                  phase_in = PH_LEN;
                  has_res  = 1'b1;
               end
               PH_LEN: begin
                  if (in_byte > max_len_ff) begin
                     has_res      = 1'b1;
                     res.done_res = 1'b1;
                     res.status   = ST_LEN_TOO_BIG;
                     restart      = 1'b1;
                  end else begin
                     sum_in   = sum_add;
                     dlen_in  = in_byte;
                     count_in = '0;
                     phase_in = (in_byte == 8'd0) ? PH_CSUM : PH_DATA;
                     has_res  = 1'b1;
                  end
               end
               PH_DATA: begin
                  sum_in   = sum_add;
                  count_in = count_inc;
                  if (count_inc >= dlen_ff) begin
                     phase_in = PH_CSUM;
                  end
                  has_res = 1'b1;
               end
               PH_CSUM: begin
                  has_res = 1'b1;
                  if (in_byte != sum_ff) begin
                     res.done_res = 1'b1;
                     res.status   = ST_CSUM_MISMATCH;
                     restart      = 1'b1;
                  end else begin
                     phase_in = PH_END;
                  end
               end
               default: begin
                  has_res = 1'b1;
                  restart = 1'b1;
                  res.done_res = 1'b1;
                  if (in_byte != END_BYTE) begin
                     res.status = ST_BAD_END;
                  end else begin
                     res.status       = ST_OK;
                     res.frame_length = {1'b0, dlen_ff} + FRAME_OVERHEAD;
                  end
               end
            endcase
            // a stored byte carries its index
            if (has_res && !res.done_res
                || has_res && res.done_res && res.status == ST_OK) begin
               res.has_byte   = 1'b1;
               res.frame_byte = in_byte;
               res.byte_index = index_ff;
               index_in       = index_ff + 9'd1;
            end
         end
         OP_TICK: begin
            idle_in = idle_inc;
            if (idle_inc >= tick_limit) begin
               has_res      = 1'b1;
               res.done_res = 1'b1;
               res.status   = timeout_status;
               restart      = 1'b1;
            end
         end
         OP_ABORT: begin
            restart = 1'b1;
         end
         default: ;
      endcase

      // back to hunting after a final result or an abort
      if (restart) begin
         phase_in = PH_HUNT;
         sum_in   = '0;
         count_in = '0;
         dlen_in  = '0;
         idle_in  = '0;
         index_in = '0;
      end
   end

   // an item with no result never waits on the output side
   assign step_ready = !has_res || out_free;
   assign fire       = in_valid && step_ready;
   assign push       = fire && has_res;
   assign push_item  = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_ff   <= '0;
         count_ff <= '0;
         dlen_ff  <= '0;
         idle_ff  <= '0;
         index_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         dlen_ff  <= dlen_in;
         idle_ff  <= idle_in;
         index_ff <= index_in;
      end
   end

endmodule

`default_nettype wire

// File: design/mfr_out_reg.sv
`default_nettype none

module mfr_out_reg
   import mfr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rsp_item_type  push_item,
   output logic               out_free,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output rsp_item_type       rsp_item
);

   logic         valid_ff;
   rsp_item_type item_ff;

   // free when empty or when the held item leaves this cycle
   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: design/meter_frame_receiver.sv
// Meter frame receiver: deframes a byte stream of start byte, 4 address
// bytes, control, length, data, additive checksum and end byte.
// Request channel (req_): one item per byte received, timer tick or abort,
// kind in req_tuser, byte in req_tdata. Response channel (rsp_): at most one
// item per request; each stored frame byte with its index, and a final item
// (rsp_tlast high) with status and frame length that ends each attempt but an abort.
// Configuration (csr_): timeouts, maximum data length and hunt limit,
// written one register per cycle, no read-back.
// Path: a request taken is held in the input register, and its response is
// then registered in the output register. Throughput: one item per cycle
// while no response waits on a full output register; the only loop is the
// frame state update, which is combinational.
// Reset puts the registers at their reset values and the block to hunting
// for a start byte; both registers come up empty.
// When rsp_tready is low the output register holds its item; the input
// register still takes and retires requests that give no response, and
// holds the first one that does until the output register frees.
`default_nettype none

module meter_frame_receiver
   import mfr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] rx_byte
   input  wire logic [1:0]   req_tuser,   // [1:0] operation
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // [7:0] frame_byte, [16:8] byte_index,
                                          // [20:17] status, [29:21] frame_length
   output logic              rsp_tlast,   // done_res
   output logic              rsp_tuser,   // has_byte
   // configuration port
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   logic         in_valid_ff;
   logic [1:0]   in_op_ff;
   logic [7:0]   in_byte_ff;
   logic         step_ready;
   logic         out_free;
   logic         push;
   rsp_item_type push_item;
   rsp_item_type rsp_item;

   // input register
   assign req_tready = !in_valid_ff || step_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   mfr_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (in_valid_ff),
      .in_op      (in_op_ff),
      .in_byte    (in_byte_ff),
      .out_free   (out_free),
      .step_ready (step_ready),
      .push       (push),
      .push_item  (push_item)
   );

   mfr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .out_free  (out_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // response packing
   assign rsp_tdata = {2'b00, rsp_item.frame_length, rsp_item.status,
                       rsp_item.byte_index, rsp_item.frame_byte};
   assign rsp_tlast = rsp_item.done_res;
   assign rsp_tuser = rsp_item.has_byte;

endmodule

`default_nettype wire

// File: tb/meter_frame_receiver_test.sv
`timescale 1ns / 1ps

module meter_frame_receiver_test;
   import mfr_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;   // kind the block ignores

   localparam int IDLE_PCT        = 23;
   localparam int SETTLE_CYCLES   = 4;
   localparam int TAIL_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int PRESSURE_AT     = 150;
   localparam int PRESSURE_CYCLES = 300;
   localparam int PHASE_ITEMS     = 140;
   localparam int RANDOM_PHASES   = 8;

   // directed rows: predicted, known silent, known result, register write
   typedef enum logic [1:0] {
      ROW_PRED,
      ROW_QUIET,
      ROW_WANT,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   code;    // item kind, or register index for writes
      logic [15:0]  value;   // rx_byte in [7:0], or register data
      rsp_item_type want;
   } stim_row_type;

   localparam rsp_item_type NO_RSP = '0;
   localparam int DIRECTED_ROWS = 29;

   localparam stim_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // ignored kind, then a noise byte while hunting
      '{ROW_QUIET, OP_UNUSED, 16'h00FF, NO_RSP},
      '{ROW_QUIET, OP_BYTE,   16'h0000, NO_RSP},
      // good frame with zero data length
      '{ROW_WANT,  OP_BYTE,   16'h0068, '{1'b1, 8'h68, 9'd0, 1'b0, ST_OK, 9'd0}},
      '{ROW_PRED,  OP_BYTE,   16'h00FF, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h0000, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h0001, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h0080, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h0053, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h0000, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h003B, NO_RSP},
      '{ROW_WANT,  OP_BYTE,   16'h0016, '{1'b1, 8'h16, 9'd8, 1'b1, ST_OK, 9'd9}},
      // lone tick, new start, abort
      '{ROW_QUIET, OP_TICK,   16'h0000, NO_RSP},
      '{ROW_WANT,  OP_BYTE,   16'h0068, '{1'b1, 8'h68, 9'd0, 1'b0, ST_OK, 9'd0}},
      '{ROW_QUIET, OP_ABORT,  16'h0000, NO_RSP},
      // zero hunt limit and timeouts act as one; zero maximum data length
      '{ROW_CSR,   CFG_HUNT_LIMIT,   16'h0000, NO_RSP},
      '{ROW_CSR,   CFG_HUNT_TIMEOUT, 16'h0000, NO_RSP},
      '{ROW_CSR,   CFG_BYTE_TIMEOUT, 16'h0000, NO_RSP},
      '{ROW_CSR,   CFG_MAX_DATA_LEN, 16'h0000, NO_RSP},
      '{ROW_WANT,  OP_BYTE,   16'h00AA, '{1'b0, 8'h00, 9'd0, 1'b1, ST_NO_START, 9'd0}},
      '{ROW_WANT,  OP_TICK,   16'h0000, '{1'b0, 8'h00, 9'd0, 1'b1, ST_HUNT_TIMEOUT, 9'd0}},
      '{ROW_WANT,  OP_BYTE,   16'h0068, '{1'b1, 8'h68, 9'd0, 1'b0, ST_OK, 9'd0}},
      '{ROW_WANT,  OP_TICK,   16'h0000, '{1'b0, 8'h00, 9'd0, 1'b1, ST_ADDR_TIMEOUT, 9'd0}},
      // length above the maximum is rejected
      '{ROW_WANT,  OP_BYTE,   16'h0068, '{1'b1, 8'h68, 9'd0, 1'b0, ST_OK, 9'd0}},
      '{ROW_PRED,  OP_BYTE,   16'h0012, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h0034, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h0056, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h0078, NO_RSP},
      '{ROW_PRED,  OP_BYTE,   16'h0008, NO_RSP},
      '{ROW_WANT,  OP_BYTE,   16'h0001, '{1'b0, 8'h00, 9'd0, 1'b1, ST_LEN_TOO_BIG, 9'd0}}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   meter_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // deframer state and register copies
   phase_type   fr_phase;
   logic [7:0]  fr_sum;
   logic [7:0]  fr_count;
   logic [7:0]  fr_len;
   logic [15:0] fr_idle;
   logic [8:0]  fr_index;
   logic [15:0] cfg_hunt_to  = HUNT_TIMEOUT_RESET;
   logic [15:0] cfg_byte_to  = BYTE_TIMEOUT_RESET;
   logic [7:0]  cfg_max_len  = MAX_DATA_LEN_RESET;
   logic [7:0]  cfg_hunt_lim = HUNT_LIMIT_RESET;

   rsp_item_type frame_rsp_q[$];   // responses still owed by the block
   int  failures     = 0;
   int  rsp_seen     = 0;
   int  items_taken  = 0;
   int  quiet_cycles = 0;
   bit  steady       = 1'b0;
   bit  pressure_done = 1'b0;

   function automatic void restart_hunt();
      fr_phase = PH_HUNT;
      fr_sum   = '0;
      fr_count = '0;
      fr_len   = '0;
      fr_idle  = '0;
      fr_index = '0;
   endfunction

   function automatic rsp_item_type store_byte(input logic [7:0] b);
      rsp_item_type r;
      r = '0;
      r.has_byte   = 1'b1;
      r.frame_byte = b;
      r.byte_index = fr_index;
      fr_index = fr_index + 9'd1;
      return r;
   endfunction

   function automatic rsp_item_type end_attempt(input logic [3:0] st);
      rsp_item_type r;
      r = '0;
      r.done_res = 1'b1;
      r.status   = st;
      restart_hunt();
      return r;
   endfunction

   // advance the deframer by one item; returns 1 when a response is due
   function automatic bit deframe_step(input logic [1:0] op, input logic [7:0] b,
                                       output rsp_item_type r);
      logic [15:0] limit;
      r = '0;
      if (op == OP_TICK) begin
         limit = (fr_phase == PH_HUNT) ? cfg_hunt_to : cfg_byte_to;
         if (limit == 16'd0) limit = 16'd1;
         if (fr_idle != 16'hFFFF) fr_idle = fr_idle + 16'd1;
         if (fr_idle < limit) return 1'b0;
         case (fr_phase)
            PH_HUNT: r = end_attempt(ST_HUNT_TIMEOUT);
            PH_ADDR: r = end_attempt(ST_ADDR_TIMEOUT);
            PH_CTRL: r = end_attempt(ST_CTRL_TIMEOUT);
            PH_LEN:  r = end_attempt(ST_LEN_TIMEOUT);
            PH_DATA: r = end_attempt(ST_DATA_TIMEOUT);
            PH_CSUM: r = end_attempt(ST_CSUM_TIMEOUT);
            default: r = end_attempt(ST_END_TIMEOUT);
         endcase
         return 1'b1;
      end
      if (op == OP_ABORT) begin
         restart_hunt();
         return 1'b0;
      end
      if (op != OP_BYTE) return 1'b0;

      fr_idle = '0;
      case (fr_phase)
         PH_HUNT: begin
            if (b == START_BYTE) begin
               fr_sum   = b;
               fr_count = '0;
               fr_phase = PH_ADDR;
               r = store_byte(b);
               return 1'b1;
            end
            fr_count = fr_count + 8'd1;
            if (fr_count >= cfg_hunt_lim || cfg_hunt_lim == 8'd0) begin
               r = end_attempt(ST_NO_START);
               return 1'b1;
            end
            return 1'b0;
         end
         PH_ADDR: begin
            fr_sum   = fr_sum + b;
            fr_count = fr_count + 8'd1;
            if (fr_count >= ADDR_BYTES) fr_phase = PH_CTRL;
            r = store_byte(b);
         end
         PH_CTRL: begin
            fr_sum   = fr_sum + b;
            fr_phase = PH_LEN;
            r = store_byte(b);
         end
         PH_LEN: begin
            if (b > cfg_max_len) begin
               r = end_attempt(ST_LEN_TOO_BIG);
            end else begin
               fr_sum   = fr_sum + b;
               fr_len   = b;
               fr_count = '0;
               fr_phase = (b == 8'd0) ? PH_CSUM : PH_DATA;
               r = store_byte(b);
            end
         end
         PH_DATA: begin
            fr_sum   = fr_sum + b;
            fr_count = fr_count + 8'd1;
            if (fr_count >= fr_len) fr_phase = PH_CSUM;
            r = store_byte(b);
         end
         PH_CSUM: begin
            if (b != fr_sum) begin
               r = end_attempt(ST_CSUM_MISMATCH);
            end else begin
               fr_phase = PH_END;
               r = store_byte(b);
            end
         end
         default: begin
            if (b != END_BYTE) begin
               r = end_attempt(ST_BAD_END);
            end else begin
               // end byte and final status share one item
               r = store_byte(b);
               r.done_res     = 1'b1;
               r.status       = ST_OK;
               r.frame_length = {1'b0, fr_len} + FRAME_OVERHEAD;
               restart_hunt();
            end
         end
      endcase
      return 1'b1;
   endfunction

   function automatic string rsp_text(input rsp_item_type r);
      return $sformatf("has_byte=%0d byte=%02h index=%0d last=%0d status=%0d length=%0d",
                       r.has_byte, r.frame_byte, r.byte_index, r.done_res, r.status,
                       r.frame_length);
   endfunction

   // offer one item, wait for the handshake, then record what is owed
   task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                            input row_kind_type kind, input rsp_item_type want);
      rsp_item_type r;
      bit got;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      got = deframe_step(op, b, r);
      if (kind == ROW_WANT) frame_rsp_q.push_back(want);
      else if (kind == ROW_PRED && got) frame_rsp_q.push_back(r);
      if (op != OP_UNUSED) items_taken++;
      @(negedge clock);
   endtask

   // registers change only with the block idle and nothing owed
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (frame_rsp_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CFG_HUNT_TIMEOUT: cfg_hunt_to  = value;
         CFG_BYTE_TIMEOUT: cfg_byte_to  = value;
         CFG_MAX_DATA_LEN: cfg_max_len  = value[7:0];
         default:          cfg_hunt_lim = value[7:0];
      endcase
   endtask

   // occasional tick run, abort or ignored item ahead of a byte
   task automatic maybe_disturb();
      int pick;
      int run;
      pick = $urandom_range(99);
      if (pick < 6) begin
         run = (cfg_byte_to <= 40) ? $urandom_range(1, cfg_byte_to + 1) : $urandom_range(1, 6);
         repeat (run) send_item(OP_TICK, 8'($urandom), ROW_PRED, NO_RSP);
      end else if (pick == 6) begin
         send_item(OP_ABORT, 8'($urandom), ROW_PRED, NO_RSP);
      end else if (pick == 7) begin
         send_item(OP_UNUSED, 8'($urandom), ROW_PRED, NO_RSP);
      end
   endtask

   task automatic send_stream_byte(input logic [7:0] b);
      maybe_disturb();
      send_item(OP_BYTE, b, ROW_PRED, NO_RSP);
   endtask

   // mostly well-formed frame with random content and rare faults
   task automatic send_frame_attempt();
      logic [7:0] sum;
      logic [7:0] dlen;
      logic [7:0] b;
      int pick;
      repeat ($urandom_range(0, 2)) send_stream_byte(8'($urandom));
      sum = START_BYTE;
      send_stream_byte(START_BYTE);
      // address bytes and control byte
      repeat (ADDR_BYTES + 1) begin
         b = 8'($urandom);
         sum = sum + b;
         send_stream_byte(b);
      end
      pick = $urandom_range(99);
      if (pick < 8) dlen = 8'($urandom);
      else if (pick < 12) dlen = cfg_max_len;
      else dlen = 8'($urandom_range(0, (cfg_max_len < 10) ? cfg_max_len : 10));
      sum = sum + dlen;
      send_stream_byte(dlen);
      repeat (dlen) begin
         b = 8'($urandom);
         sum = sum + b;
         send_stream_byte(b);
      end
      send_stream_byte(($urandom_range(99) < 92) ? sum : sum + 8'($urandom_range(1, 255)));
      send_stream_byte(($urandom_range(99) < 92) ? END_BYTE
                                                 : END_BYTE ^ 8'($urandom_range(1, 255)));
   endtask

   // response checking at the rising edge
   always @(posedge clock) begin : check_rsp
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = {rsp_tuser, rsp_tdata[7:0], rsp_tdata[16:8], rsp_tlast, rsp_tdata[20:17],
                 rsp_tdata[29:21]};
         rsp_seen++;
         if (frame_rsp_q.size() == 0) begin
            failures++;
            if (failures <= 10) $display("response with none owed: %s", rsp_text(seen));
         end else begin
            want = frame_rsp_q.pop_front();
            if (seen !== want) begin
               failures++;
               if (failures <= 10)
                  $display("response mismatch\n  expected %s\n  actual   %s",
                           rsp_text(want), rsp_text(seen));
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response ready: random stalls, one long hold-off, a steady stretch
   initial begin : drive_rsp_ready
      int held;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!pressure_done && rsp_seen >= PRESSURE_AT) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < PRESSURE_CYCLES; held++) @(negedge clock);
            pressure_done = 1'b1;
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin : drive_stimulus
      int phase_no;
      int start;
      logic [15:0] ht;
      logic [15:0] bt;
      logic [7:0]  ml;
      logic [7:0]  hl;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      restart_hunt();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_CSR)
            write_reg(DIRECTED[i].code, DIRECTED[i].value);
         else
            send_item(DIRECTED[i].code, DIRECTED[i].value[7:0], DIRECTED[i].kind,
                      DIRECTED[i].want);
      end

      // random phases, each under its own register setting
      for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
         case (phase_no)
            0: begin
               ht = 16'd1;
               bt = 16'd1;
               ml = 8'd0;
               hl = 8'd1;
            end
            1: begin
               ht = 16'hFFFF;
               bt = 16'hFFFF;
               ml = 8'hFF;
               hl = 8'hFF;
            end
            default: begin
               ht = 16'($urandom_range(1, 60));
               bt = 16'($urandom_range(1, 30));
               ml = 8'($urandom_range(0, 24));
               hl = 8'($urandom_range(1, 40));
            end
         endcase
         write_reg(CFG_HUNT_TIMEOUT, ht);
         write_reg(CFG_BYTE_TIMEOUT, bt);
         write_reg(CFG_MAX_DATA_LEN, {8'h00, ml});
         write_reg(CFG_HUNT_LIMIT, {8'h00, hl});
         steady = (phase_no == 3);
         start = items_taken;
         while (items_taken - start < PHASE_ITEMS) send_frame_attempt();
      end
      steady = 1'b0;

      // drain and report
      req_tvalid <= 1'b0;
      while (frame_rsp_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (failures == 0 && frame_rsp_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
